### src/spadd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spadd_pkg
// Shared types and codes for the sparse polynomial add/merge block.
// ----------------------------------------------------------------------------
package spadd_pkg;

  localparam logic [1:0] OP_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] OP_LOAD_SECOND = 2'd1;
  localparam logic [1:0] OP_START       = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] coeff;
    logic [15:0]        expo;
  } in_t;

  typedef struct packed {
    logic signed [16:0] sum_coeff;
    logic [15:0]        term_expo;
    logic               has_term;
    logic               last;
  } out_t;

  // One stored term, coefficient in the upper half
  typedef struct packed {
    logic signed [15:0] coeff;
    logic [15:0]        expo;
  } term_t;

  // Decision of the merge unit for one step
  typedef struct packed {
    logic               take_first;
    logic               take_second;
    logic signed [16:0] sum_coeff;
    logic [15:0]        term_expo;
  } merge_t;

endpackage

### src/sparse_poly_add_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_poly_add_merge
// Adds two sparse polynomials by a sorted merge of two term stores.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data): a load beat (op 0 or 1) writes a
// term into the first or second store; loads beyond MAX_TERMS
// are dropped, op 3 is ignored. A start beat (op 2) runs the merge, during
// which in_ready is low.
// Output channel (out_valid/out_ready/out_data): one beat per merged term,
// largest exponent first, ties summed; the final beat carries last. With both
// stores empty a single beat goes out with has_term low.
// Sequence: each result goes through a store read (S_FETCH), then a
// compare/add through the shared merge unit (S_MERGE). The result sits
// in an output register: a stall on out_ready holds the sequencer before the
// next compare. Both stores are empty once the last beat is produced.
// Reset clears the counts, pointers, sequencer and output valid; store
// contents are not cleared.
// ----------------------------------------------------------------------------
module sparse_poly_add_merge #(
  parameter int MAX_TERMS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  spadd_pkg::in_t    in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output spadd_pkg::out_t   out_data
);

  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_MERGE = 2'd2;

  logic [1:0]        state;
  logic [CW-1:0]     count_first;
  logic [CW-1:0]     count_second;
  logic [CW-1:0]     read_ptr_first;
  logic [CW-1:0]     read_ptr_second;
  logic [CW-1:0]     read_ptr_first_next;
  logic [CW-1:0]     read_ptr_second_next;

  logic              in_beat;
  logic              load_first;
  logic              load_second;
  logic              start;
  logic              have_first;
  logic              have_second;
  logic              out_free;
  logic              done;
  spadd_pkg::term_t  wr_term;
  spadd_pkg::term_t  rd_first;
  spadd_pkg::term_t  rd_second;
  spadd_pkg::merge_t res;

  assign in_ready    = (state == S_IDLE);
  assign in_beat     = in_valid && in_ready;
  assign load_first  = in_beat && (in_data.op == spadd_pkg::OP_LOAD_FIRST)
                       && (count_first < CW'(MAX_TERMS));
  assign load_second = in_beat && (in_data.op == spadd_pkg::OP_LOAD_SECOND)
                       && (count_second < CW'(MAX_TERMS));
  assign start       = in_beat && (in_data.op == spadd_pkg::OP_START);

  assign wr_term.coeff = in_data.coeff;
  assign wr_term.expo  = in_data.expo;

  assign have_first  = read_ptr_first  < count_first;
  assign have_second = read_ptr_second < count_second;

  spadd_store #(.DEPTH(MAX_TERMS), .AW(AW)) u_store_first (
    .clk     (clk),
    .wr_en   (load_first),
    .wr_addr (count_first[AW-1:0]),
    .wr_data (wr_term),
    .rd_en   ((state == S_FETCH) && have_first),
    .rd_addr (read_ptr_first[AW-1:0]),
    .rd_data (rd_first)
  );

  spadd_store #(.DEPTH(MAX_TERMS), .AW(AW)) u_store_second (
    .clk     (clk),
    .wr_en   (load_second),
    .wr_addr (count_second[AW-1:0]),
    .wr_data (wr_term),
    .rd_en   ((state == S_FETCH) && have_second),
    .rd_addr (read_ptr_second[AW-1:0]),
    .rd_data (rd_second)
  );

  spadd_merge_unit u_merge (
    .have_first  (have_first),
    .have_second (have_second),
    .first       (rd_first),
    .second      (rd_second),
    .res         (res)
  );

  assign read_ptr_first_next  = read_ptr_first  + CW'(res.take_first);
  assign read_ptr_second_next = read_ptr_second + CW'(res.take_second);
  assign done     = !(read_ptr_first_next < count_first)
                    && !(read_ptr_second_next < count_second);
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      count_first     <= '0;
      count_second    <= '0;
      read_ptr_first  <= '0;
      read_ptr_second <= '0;
      out_valid       <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (load_first) begin
            count_first <= count_first + CW'(1);
          end
          if (load_second) begin
            count_second <= count_second + CW'(1);
          end
          if (start) begin
            read_ptr_first  <= '0;
            read_ptr_second <= '0;
            state           <= S_FETCH;
          end
        end
        S_FETCH: begin
          state <= S_MERGE;
        end
        S_MERGE: begin
          // hold until the output register can take the next beat
          if (out_free) begin
            if (done) begin
              count_first     <= '0;
              count_second    <= '0;
              read_ptr_first  <= '0;
              read_ptr_second <= '0;
              state           <= S_IDLE;
            end else begin
              read_ptr_first  <= read_ptr_first_next;
              read_ptr_second <= read_ptr_second_next;
              state           <= S_FETCH;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if ((state == S_MERGE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_MERGE) && out_free) begin
      out_data.sum_coeff <= res.sum_coeff;
      out_data.term_expo <= res.term_expo;
      out_data.has_term  <= res.take_first || res.take_second;
      out_data.last      <= done;
    end
  end

endmodule

### src/spadd_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spadd_store
// Term store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module spadd_store #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  spadd_pkg::term_t  wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output spadd_pkg::term_t  rd_data
);

  spadd_pkg::term_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/spadd_merge_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spadd_merge_unit
// Shared compare/add step: picks the larger exponent, sums on a tie.
// ----------------------------------------------------------------------------
module spadd_merge_unit (
  input  logic              have_first,
  input  logic              have_second,
  input  spadd_pkg::term_t  first,
  input  spadd_pkg::term_t  second,
  output spadd_pkg::merge_t res
);

  logic               a_gt;
  logic               a_lt;
  logic signed [16:0] ca;
  logic signed [16:0] cb;

  assign a_gt = first.expo > second.expo;
  assign a_lt = first.expo < second.expo;

  always_comb begin
    res.take_first  = have_first  && (!have_second || !a_lt);
    res.take_second = have_second && (!have_first  || !a_gt);
    // zero the operand that is not taken so one adder covers all cases
    ca = res.take_first  ? {first.coeff[15], first.coeff}   : 17'sd0;
    cb = res.take_second ? {second.coeff[15], second.coeff} : 17'sd0;
    res.sum_coeff = ca + cb;
    if (res.take_first) begin
      res.term_expo = first.expo;
    end else if (res.take_second) begin
      res.term_expo = second.expo;
    end else begin
      res.term_expo = '0;
    end
  end

endmodule

### src/spadd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spadd_checker
// Port-level checks for the sparse polynomial add/merge block.
// ----------------------------------------------------------------------------
module spadd_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input spadd_pkg::in_t  in_data,
  input logic            out_valid,
  input logic            out_ready,
  input spadd_pkg::out_t out_data
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // a start beat closes the input until the merge is over
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_data.op == spadd_pkg::OP_START) |=> !in_ready)
    else $error("input open right after start");

  // while a beat that is not the last one is offered, the merge is still running
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last |-> !in_ready)
    else $error("input open in the middle of a merge");

  // the empty result is always the only and final one, with a zero term
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.has_term |->
      out_data.last && (out_data.sum_coeff == 17'sd0) && (out_data.term_expo == 16'd0))
    else $error("malformed empty result");

endmodule

bind sparse_poly_add_merge spadd_checker u_spadd_checker (.*);
